// File: rtl/sdes_pkg.sv
// shared tables and permutation functions for the s-des cipher unit
package sdes_pkg;

    localparam int unsigned KeyWidth   = 10;
    localparam int unsigned BlockWidth = 8;
    localparam int unsigned HalfWidth  = 4;

    typedef logic [KeyWidth-1:0]   key_t;
    typedef logic [BlockWidth-1:0] block_t;
    typedef logic [HalfWidth-1:0]  half_t;
    typedef logic [1:0]            sbox_val_t;

    typedef enum logic {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } command_t;

    // bit positions, 1 is the msb
    localparam int unsigned TabP10 [10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
    localparam int unsigned TabP8 [8]   = '{6, 3, 7, 4, 8, 5, 10, 9};
    localparam int unsigned TabIp [8]   = '{2, 6, 3, 1, 4, 8, 5, 7};
    localparam int unsigned TabIpInv [8] = '{4, 1, 3, 5, 7, 2, 8, 6};
    localparam int unsigned TabEp [8]   = '{4, 1, 2, 3, 2, 3, 4, 1};
    localparam int unsigned TabP4 [4]   = '{2, 4, 3, 1};

    localparam sbox_val_t Sbox0 [4][4] = '{
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd3, 2'd1, 2'd3, 2'd2}
    };
    localparam sbox_val_t Sbox1 [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd2, 2'd0, 2'd1, 2'd3},
        '{2'd3, 2'd0, 2'd1, 2'd0},
        '{2'd2, 2'd1, 2'd0, 2'd3}
    };

    function automatic key_t perm_p10(input key_t v);
        key_t r;
        r = '0;
        for (int i = 0; i < 10; i++) begin
            r[4'(9 - i)] = v[4'(10 - TabP10[i])];
        end
        return r;
    endfunction

    function automatic block_t perm_p8(input key_t v);
        block_t r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[3'(7 - i)] = v[4'(10 - TabP8[i])];
        end
        return r;
    endfunction

    function automatic block_t perm_ip(input block_t v);
        block_t r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[3'(7 - i)] = v[3'(8 - TabIp[i])];
        end
        return r;
    endfunction

    function automatic block_t perm_ip_inv(input block_t v);
        block_t r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[3'(7 - i)] = v[3'(8 - TabIpInv[i])];
        end
        return r;
    endfunction

    function automatic block_t perm_ep(input half_t v);
        block_t r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[3'(7 - i)] = v[2'(4 - TabEp[i])];
        end
        return r;
    endfunction

    function automatic half_t perm_p4(input half_t v);
        half_t r;
        r = '0;
        for (int i = 0; i < 4; i++) begin
            r[2'(3 - i)] = v[2'(4 - TabP4[i])];
        end
        return r;
    endfunction

    // rotate each five-bit half left by one place
    function automatic key_t rotl1_halves(input key_t v);
        return {v[8:5], v[9], v[3:0], v[4]};
    endfunction

    // rotate each five-bit half left by three places
    function automatic key_t rotl3_halves(input key_t v);
        return {v[6:5], v[9:7], v[1:0], v[4:2]};
    endfunction

    function automatic half_t round_f(input half_t half, input block_t subkey);
        block_t    x;
        sbox_val_t s0;
        sbox_val_t s1;
        x  = perm_ep(half) ^ subkey;
        s0 = Sbox0[{x[7], x[4]}][x[6:5]];
        s1 = Sbox1[{x[3], x[0]}][x[2:1]];
        return perm_p4({s0, s1});
    endfunction

endpackage

// File: rtl/sdes_block_cipher_unit.sv
// s-des block cipher unit: three-stage pipeline, one block per cycle unless m_ready stalls
//
//   channel  | ports                        | direction | item
//   ---------+------------------------------+-----------+---------------------------
//   s_       | s_valid s_ready s_command    | in        | command and 8-bit block
//            | s_data_in                    |           |
//   m_       | m_valid m_ready m_data_out   | out       | 8-bit result block
//   cfg_     | cfg_wr_en cfg_wr_data        | in        | 10-bit key, no handshake
//
// three register stages: an accepted item passes through the stage one, two
// and three registers to m_, and a new item is accepted each cycle unless
// m_ready stalls. stage one does ip, stage two round one and the swap, stage
// three round two and ip inverse, and the last stage is the output register.
// subkeys come straight from the key register. synchronous active-low reset
// clears the valid bits and the key. a stall on m_ready holds the stages;
// bubbles close up so s_ready only falls when all three stages hold items.
module sdes_block_cipher_unit
    import sdes_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [KeyWidth-1:0]   cfg_wr_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [BlockWidth-1:0] s_data_in,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BlockWidth-1:0] m_data_out
);

    key_t     cipher_key_reg;
    key_t     k10;
    block_t   k1;
    block_t   k2;

    logic     st1_valid_reg;
    logic     st2_valid_reg;
    logic     st3_valid_reg;
    logic     adv1;
    logic     adv2;
    logic     adv3;

    command_t st1_cmd_reg;
    block_t   st1_data_reg;
    block_t   st1_data_next;

    command_t st2_cmd_reg;
    block_t   st2_data_reg;
    block_t   st2_data_next;
    block_t   st2_subkey;

    block_t   st3_data_reg;
    block_t   st3_data_next;
    block_t   st3_subkey;
    half_t    st3_left;

    // key schedule
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cipher_key_reg <= '0;
        end else if (cfg_wr_en) begin
            cipher_key_reg <= cfg_wr_data;
        end
    end

    assign k10 = perm_p10(cipher_key_reg);
    assign k1  = perm_p8(rotl1_halves(k10));
    assign k2  = perm_p8(rotl3_halves(k10));

    // pipeline flow control
    assign adv3    = !st3_valid_reg || m_ready;
    assign adv2    = !st2_valid_reg || adv3;
    assign adv1    = !st1_valid_reg || adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end else begin
            if (adv1) begin
                st1_valid_reg <= s_valid;
            end
            if (adv2) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (adv3) begin
                st3_valid_reg <= st2_valid_reg;
            end
        end
    end

    // stage one: initial permutation
    assign st1_data_next = perm_ip(s_data_in);

    // stage two: round one then swap
    always_comb begin
        st2_subkey    = (st1_cmd_reg == CMD_DECRYPT) ? k2 : k1;
        st2_data_next = {st1_data_reg[3:0],
                         st1_data_reg[7:4] ^ round_f(st1_data_reg[3:0], st2_subkey)};
    end

    // stage three: round two then inverse permutation
    always_comb begin
        st3_subkey    = (st2_cmd_reg == CMD_DECRYPT) ? k1 : k2;
        st3_left      = st2_data_reg[7:4] ^ round_f(st2_data_reg[3:0], st3_subkey);
        st3_data_next = perm_ip_inv({st3_left, st2_data_reg[3:0]});
    end

    always_ff @(posedge aclk) begin
        if (adv1 && s_valid) begin
            st1_cmd_reg  <= command_t'(s_command);
            st1_data_reg <= st1_data_next;
        end
        if (adv2 && st1_valid_reg) begin
            st2_cmd_reg  <= st1_cmd_reg;
            st2_data_reg <= st2_data_next;
        end
        if (adv3 && st2_valid_reg) begin
            st3_data_reg <= st3_data_next;
        end
    end

    assign m_valid    = st3_valid_reg;
    assign m_data_out = st3_data_reg;

endmodule

// File: rtl/sdes_checker.sv
// port-level checks for the s-des cipher unit, bound to the top level
module sdes_checker
    import sdes_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [BlockWidth-1:0] m_data_out
);

    // nothing comes out the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a result waiting to be taken holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out))
        else $error("result dropped or changed while stalled");

    // an empty output stage means the pipeline can take an item
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output stage");

    // no result appears out of an empty pipeline unless an item was accepted before it
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid ##1 !m_valid ##1 !m_valid ##1 !(s_valid && s_ready) ##1 !m_valid
            |-> ##1 !m_valid || $past(s_valid && s_ready, 2) || $past(s_valid && s_ready, 3)
            || $past(s_valid && s_ready, 1) || $past(s_valid && s_ready, 4))
        else $error("result without an accepted item");

endmodule

bind sdes_block_cipher_unit sdes_checker u_sdes_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_data_out (m_data_out)
);
